// ===== sv/thml_pkg.sv =====
// Shared constants, status and format codes, and types for texture_header_mip_layout.
// Used by thml_addcmp, thml_level_unit and the top level; depends on nothing.
package thml_pkg;

  localparam int MAX_MIP_LEVELS = 8;

  localparam int DW = 36;
  typedef logic [DW-1:0] word_t;

  localparam logic [31:0] MAGIC_TIM2     = 32'h324D_4954;
  localparam logic [7:0]  FILE_HDR_BYTES = 8'd16;
  localparam logic [7:0]  PIC_HDR_BYTES  = 8'h30;
  localparam logic [7:0]  PIC_BASE_WIDE  = 8'd128;
  localparam logic [10:0] PALETTE_BYTES  = 11'(256 * 4);
  localparam logic [3:0]  ALIGN_MASK     = 4'd15;

  localparam logic [7:0] PTYPE_RGBA16 = 8'h01;
  localparam logic [7:0] PTYPE_RGBA32 = 8'h03;
  localparam logic [7:0] PTYPE_IDX8   = 8'h05;

  localparam logic [1:0] FMT_RGBA32 = 2'd0;
  localparam logic [1:0] FMT_RGBA16 = 2'd1;
  localparam logic [1:0] FMT_IDX8   = 2'd2;

  localparam logic [3:0] STAT_OK      = 4'd0;
  localparam logic [3:0] STAT_SHORT   = 4'd1;
  localparam logic [3:0] STAT_MAGIC   = 4'd2;
  localparam logic [3:0] STAT_NOPIC   = 4'd3;
  localparam logic [3:0] STAT_TRUNC   = 4'd4;
  localparam logic [3:0] STAT_TYPE    = 4'd5;
  localparam logic [3:0] STAT_MIPS    = 4'd6;
  localparam logic [3:0] STAT_NOCLUT  = 4'd7;
  localparam logic [3:0] STAT_PAYLOAD = 4'd8;
  localparam logic [3:0] STAT_LEVEL   = 4'd9;
  localparam logic [3:0] STAT_CLUTBND = 4'd10;

  typedef struct packed {
    logic [15:0] w;
    logic [15:0] h;
    logic [33:0] sz;
    logic [34:0] sz_al;
  } lvl_info_t;

endpackage

// ===== sv/thml_addcmp.sv =====
// Shared adder and comparator: sum = a + b, gt = (a + b) > c.
// Depends on thml_pkg for the datapath word type.
module thml_addcmp (
  input  thml_pkg::word_t a,
  input  thml_pkg::word_t b,
  input  thml_pkg::word_t c,
  output thml_pkg::word_t sum,
  output logic            gt
);

  assign sum = a + b;
  assign gt  = (sum > c);

endmodule

// ===== sv/thml_level_unit.sv =====
// Mip level geometry: clamped width and height, byte size and 16-byte aligned size.
// Depends on thml_pkg; size is registered from lvl, aligned size from sz_r.
module thml_level_unit (
  input  logic                clk,
  input  logic [3:0]          lvl,
  input  logic [15:0]         base_w,
  input  logic [15:0]         base_h,
  input  logic [1:0]          bpp_sh,
  output thml_pkg::lvl_info_t info
);

  logic [15:0] w_sh;
  logic [15:0] h_sh;
  logic [15:0] w_nxt;
  logic [15:0] h_nxt;
  logic [31:0] prod;
  logic [15:0] w_r;
  logic [15:0] h_r;
  logic [33:0] sz_r;
  logic [34:0] sz_al_r;

  assign w_sh  = base_w >> lvl;
  assign h_sh  = base_h >> lvl;
  assign w_nxt = (w_sh == 16'd0) ? 16'd1 : w_sh;
  assign h_nxt = (h_sh == 16'd0) ? 16'd1 : h_sh;
  assign prod  = w_nxt * h_nxt;

  always_ff @(posedge clk) begin
    w_r     <= w_nxt;
    h_r     <= h_nxt;
    sz_r    <= {2'b00, prod} << bpp_sh;
    sz_al_r <= ({1'b0, sz_r} + 35'(thml_pkg::ALIGN_MASK)) & ~35'(thml_pkg::ALIGN_MASK);
  end

  assign info.w     = w_r;
  assign info.h     = h_r;
  assign info.sz    = sz_r;
  assign info.sz_al = sz_al_r;

endmodule

// ===== sv/texture_header_mip_layout.sv =====
// Top level: header check sequencer around one shared adder/comparator and the level unit.
// Depends on thml_pkg, thml_addcmp and thml_level_unit.
//
// Usage: a request on the in_ channel carries the header fields and blob length.
// in_stall is high from acceptance until the last result of that request is taken.
// The block answers with either one error result (status nonzero, last set) or one
// ok result per mip level, largest first, the final one with last set.
// Sequence, for n mip levels:
//   header checks run in order, one check per cycle, the arithmetic ones through the shared adder;
//   the level bounds pass then takes each level through issue, test and advance states, then the palette check;
//   each level result then passes through geometry, offset, hold and advance states, the
//   last one skipping advance; the idle state then accepts the next request.
// The single adder/comparator and the one-level-at-a-time multiplier serialize these steps.
// Results sit in an output register; while out_stall is high the result holds and
// the sequencer waits. Synchronous reset (rst_n low) returns to idle and drops any
// pending result.
module texture_header_mip_layout (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_blob_size,
  input  logic [31:0] in_magic_word,
  input  logic [7:0]  in_format_id,
  input  logic [15:0] in_picture_count,
  input  logic [31:0] in_clut_bytes,
  input  logic [31:0] in_image_bytes,
  input  logic [15:0] in_pic_header_bytes,
  input  logic [7:0]  in_mip_field,
  input  logic [7:0]  in_pixel_type,
  input  logic [15:0] in_base_width,
  input  logic [15:0] in_base_height,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  out_status,
  output logic [3:0]  out_level_index,
  output logic [31:0] out_level_offset,
  output logic [15:0] out_level_width,
  output logic [15:0] out_level_height,
  output logic [1:0]  out_texel_format,
  output logic [31:0] out_palette_offset,
  output logic        out_palette_present,
  output logic [4:0]  out_level_total,
  output logic        out_last
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_LVL_ISSUE,
    ST_LVL_TEST,
    ST_LVL_ADV,
    ST_PAL,
    ST_EMIT_ISSUE,
    ST_EMIT_LOAD,
    ST_OUT_WAIT,
    ST_EMIT_ADV
  } state_t;

  typedef enum logic [3:0] {
    CK_SHORT,
    CK_MAGIC,
    CK_NOPIC,
    CK_TRUNC,
    CK_TYPE,
    CK_MIPS,
    CK_NOCLUT,
    CK_HDR,
    CK_PAYLOAD
  } chk_step_t;

  state_t      state_r, state_nxt;
  chk_step_t   step_r, step_nxt;

  logic [31:0] blob_r, blob_nxt;
  logic [31:0] magic_r, magic_nxt;
  logic [7:0]  pbase_r, pbase_nxt;
  logic [15:0] pics_r, pics_nxt;
  logic [31:0] clut_r, clut_nxt;
  logic [31:0] img_r, img_nxt;
  logic [15:0] hdr_r, hdr_nxt;
  logic [7:0]  nlev_r, nlev_nxt;
  logic [7:0]  ptype_r, ptype_nxt;
  logic [15:0] bw_r, bw_nxt;
  logic [15:0] bh_r, bh_nxt;
  logic [1:0]  fmt_r, fmt_nxt;
  logic [1:0]  bpp_sh_r, bpp_sh_nxt;
  logic [16:0] imgoff_r, imgoff_nxt;
  logic [31:0] poff_r, poff_nxt;
  thml_pkg::word_t off_r, off_nxt;
  logic [3:0]  lvl_r, lvl_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [3:0]  out_status_r, out_status_nxt;
  logic [3:0]  out_index_r, out_index_nxt;
  logic [31:0] out_offset_r, out_offset_nxt;
  logic [15:0] out_width_r, out_width_nxt;
  logic [15:0] out_height_r, out_height_nxt;
  logic [1:0]  out_fmt_r, out_fmt_nxt;
  logic [31:0] out_poff_r, out_poff_nxt;
  logic        out_pp_r, out_pp_nxt;
  logic [4:0]  out_total_r, out_total_nxt;
  logic        out_last_r, out_last_nxt;

  thml_pkg::word_t     op_a, op_b, op_c, op_sum;
  logic                op_gt;
  thml_pkg::lvl_info_t lvl_info;
  logic                fail;
  logic [3:0]          fail_code;
  logic                lvl_last;
  logic                is_idx8;

  thml_addcmp u_addcmp (
    .a   (op_a),
    .b   (op_b),
    .c   (op_c),
    .sum (op_sum),
    .gt  (op_gt)
  );

  thml_level_unit u_level (
    .clk    (clk),
    .lvl    (lvl_r),
    .base_w (bw_r),
    .base_h (bh_r),
    .bpp_sh (bpp_sh_r),
    .info   (lvl_info)
  );

  assign lvl_last = (({4'b0000, lvl_r} + 8'd1) == nlev_r);
  assign is_idx8  = (fmt_r == thml_pkg::FMT_IDX8);

  always_comb begin
    state_nxt      = state_r;
    step_nxt       = step_r;
    blob_nxt       = blob_r;
    magic_nxt      = magic_r;
    pbase_nxt      = pbase_r;
    pics_nxt       = pics_r;
    clut_nxt       = clut_r;
    img_nxt        = img_r;
    hdr_nxt        = hdr_r;
    nlev_nxt       = nlev_r;
    ptype_nxt      = ptype_r;
    bw_nxt         = bw_r;
    bh_nxt         = bh_r;
    fmt_nxt        = fmt_r;
    bpp_sh_nxt     = bpp_sh_r;
    imgoff_nxt     = imgoff_r;
    poff_nxt       = poff_r;
    off_nxt        = off_r;
    lvl_nxt        = lvl_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_index_nxt  = out_index_r;
    out_offset_nxt = out_offset_r;
    out_width_nxt  = out_width_r;
    out_height_nxt = out_height_r;
    out_fmt_nxt    = out_fmt_r;
    out_poff_nxt   = out_poff_r;
    out_pp_nxt     = out_pp_r;
    out_total_nxt  = out_total_r;
    out_last_nxt   = out_last_r;
    op_a           = '0;
    op_b           = '0;
    op_c           = '0;
    fail           = 1'b0;
    fail_code      = thml_pkg::STAT_OK;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          blob_nxt  = in_blob_size;
          magic_nxt = in_magic_word;
          pbase_nxt = (in_format_id == 8'd0) ? thml_pkg::FILE_HDR_BYTES
                                             : thml_pkg::PIC_BASE_WIDE;
          pics_nxt  = in_picture_count;
          clut_nxt  = in_clut_bytes;
          img_nxt   = in_image_bytes;
          hdr_nxt   = in_pic_header_bytes;
          nlev_nxt  = (in_mip_field == 8'd0) ? 8'd1 : in_mip_field;
          ptype_nxt = in_pixel_type;
          bw_nxt    = in_base_width;
          bh_nxt    = in_base_height;
          step_nxt  = CK_SHORT;
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        case (step_r)
          CK_SHORT: begin
            op_a = thml_pkg::word_t'(thml_pkg::FILE_HDR_BYTES);
            op_c = thml_pkg::word_t'(blob_r);
            if (op_gt) begin
              fail      = 1'b1;
              fail_code = thml_pkg::STAT_SHORT;
            end else begin
              step_nxt = CK_MAGIC;
            end
          end
          CK_MAGIC: begin
            if (magic_r != thml_pkg::MAGIC_TIM2) begin
              fail      = 1'b1;
              fail_code = thml_pkg::STAT_MAGIC;
            end else begin
              step_nxt = CK_NOPIC;
            end
          end
          CK_NOPIC: begin
            if (pics_r == 16'd0) begin
              fail      = 1'b1;
              fail_code = thml_pkg::STAT_NOPIC;
            end else begin
              step_nxt = CK_TRUNC;
            end
          end
          CK_TRUNC: begin
            op_a = thml_pkg::word_t'(pbase_r);
            op_b = thml_pkg::word_t'(thml_pkg::PIC_HDR_BYTES);
            op_c = thml_pkg::word_t'(blob_r);
            if (op_gt) begin
              fail      = 1'b1;
              fail_code = thml_pkg::STAT_TRUNC;
            end else begin
              step_nxt = CK_TYPE;
            end
          end
          CK_TYPE: begin
            step_nxt = CK_MIPS;
            if (ptype_r == thml_pkg::PTYPE_RGBA32) begin
              fmt_nxt    = thml_pkg::FMT_RGBA32;
              bpp_sh_nxt = 2'd2;
            end else if (ptype_r == thml_pkg::PTYPE_RGBA16) begin
              fmt_nxt    = thml_pkg::FMT_RGBA16;
              bpp_sh_nxt = 2'd1;
            end else if (ptype_r == thml_pkg::PTYPE_IDX8) begin
              fmt_nxt    = thml_pkg::FMT_IDX8;
              bpp_sh_nxt = 2'd0;
            end else begin
              fail      = 1'b1;
              fail_code = thml_pkg::STAT_TYPE;
            end
          end
          CK_MIPS: begin
            if (nlev_r > 8'(thml_pkg::MAX_MIP_LEVELS)) begin
              fail      = 1'b1;
              fail_code = thml_pkg::STAT_MIPS;
            end else begin
              step_nxt = CK_NOCLUT;
            end
          end
          CK_NOCLUT: begin
            op_a = thml_pkg::word_t'(thml_pkg::PALETTE_BYTES);
            op_c = thml_pkg::word_t'(clut_r);
            if (is_idx8 && op_gt) begin
              fail      = 1'b1;
              fail_code = thml_pkg::STAT_NOCLUT;
            end else begin
              step_nxt = CK_HDR;
            end
          end
          CK_HDR: begin
            op_a       = thml_pkg::word_t'(thml_pkg::PIC_HDR_BYTES);
            op_c       = thml_pkg::word_t'(hdr_r);
            imgoff_nxt = {9'd0, pbase_r} + {1'b0, hdr_r};
            if (op_gt) begin
              fail      = 1'b1;
              fail_code = thml_pkg::STAT_PAYLOAD;
            end else begin
              step_nxt = CK_PAYLOAD;
            end
          end
          CK_PAYLOAD: begin
            op_a = thml_pkg::word_t'(imgoff_r);
            op_b = thml_pkg::word_t'(img_r);
            op_c = thml_pkg::word_t'(blob_r);
            if (op_gt) begin
              fail      = 1'b1;
              fail_code = thml_pkg::STAT_PAYLOAD;
            end else begin
              poff_nxt  = op_sum[31:0];
              off_nxt   = '0;
              lvl_nxt   = 4'd0;
              state_nxt = ST_LVL_ISSUE;
            end
          end
          default: begin
            state_nxt = ST_IDLE;
          end
        endcase
      end
      ST_LVL_ISSUE: begin
        state_nxt = ST_LVL_TEST;
      end
      ST_LVL_TEST: begin
        op_a = off_r;
        op_b = thml_pkg::word_t'(lvl_info.sz);
        op_c = thml_pkg::word_t'(img_r);
        if (op_gt) begin
          fail      = 1'b1;
          fail_code = thml_pkg::STAT_LEVEL;
        end else begin
          state_nxt = ST_LVL_ADV;
        end
      end
      ST_LVL_ADV: begin
        op_a    = off_r;
        op_b    = thml_pkg::word_t'(lvl_info.sz_al);
        off_nxt = op_sum;
        if (lvl_last) begin
          state_nxt = ST_PAL;
        end else begin
          lvl_nxt   = lvl_r + 4'd1;
          state_nxt = ST_LVL_ISSUE;
        end
      end
      ST_PAL: begin
        op_a = thml_pkg::word_t'(poff_r);
        op_b = thml_pkg::word_t'(thml_pkg::PALETTE_BYTES);
        op_c = thml_pkg::word_t'(blob_r);
        if (is_idx8 && op_gt) begin
          fail      = 1'b1;
          fail_code = thml_pkg::STAT_CLUTBND;
        end else begin
          off_nxt   = '0;
          lvl_nxt   = 4'd0;
          state_nxt = ST_EMIT_ISSUE;
        end
      end
      ST_EMIT_ISSUE: begin
        state_nxt = ST_EMIT_LOAD;
      end
      ST_EMIT_LOAD: begin
        op_a           = thml_pkg::word_t'(imgoff_r);
        op_b           = off_r;
        out_valid_nxt  = 1'b1;
        out_status_nxt = thml_pkg::STAT_OK;
        out_index_nxt  = lvl_r;
        out_offset_nxt = op_sum[31:0];
        out_width_nxt  = lvl_info.w;
        out_height_nxt = lvl_info.h;
        out_fmt_nxt    = fmt_r;
        out_poff_nxt   = is_idx8 ? poff_r : 32'd0;
        out_pp_nxt     = is_idx8;
        out_total_nxt  = nlev_r[4:0];
        out_last_nxt   = lvl_last;
        state_nxt      = ST_OUT_WAIT;
      end
      ST_OUT_WAIT: begin
        if (!out_stall) begin
          out_valid_nxt = 1'b0;
          state_nxt     = out_last_r ? ST_IDLE : ST_EMIT_ADV;
        end
      end
      ST_EMIT_ADV: begin
        op_a      = off_r;
        op_b      = thml_pkg::word_t'(lvl_info.sz_al);
        off_nxt   = op_sum;
        lvl_nxt   = lvl_r + 4'd1;
        state_nxt = ST_EMIT_ISSUE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (fail) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = fail_code;
      out_index_nxt  = 4'd0;
      out_offset_nxt = 32'd0;
      out_width_nxt  = 16'd0;
      out_height_nxt = 16'd0;
      out_fmt_nxt    = thml_pkg::FMT_RGBA32;
      out_poff_nxt   = 32'd0;
      out_pp_nxt     = 1'b0;
      out_total_nxt  = 5'd0;
      out_last_nxt   = 1'b1;
      state_nxt      = ST_OUT_WAIT;
    end
  end

  always_ff @(posedge clk) begin
    step_r       <= step_nxt;
    blob_r       <= blob_nxt;
    magic_r      <= magic_nxt;
    pbase_r      <= pbase_nxt;
    pics_r       <= pics_nxt;
    clut_r       <= clut_nxt;
    img_r        <= img_nxt;
    hdr_r        <= hdr_nxt;
    nlev_r       <= nlev_nxt;
    ptype_r      <= ptype_nxt;
    bw_r         <= bw_nxt;
    bh_r         <= bh_nxt;
    fmt_r        <= fmt_nxt;
    bpp_sh_r     <= bpp_sh_nxt;
    imgoff_r     <= imgoff_nxt;
    poff_r       <= poff_nxt;
    off_r        <= off_nxt;
    lvl_r        <= lvl_nxt;
    out_status_r <= out_status_nxt;
    out_index_r  <= out_index_nxt;
    out_offset_r <= out_offset_nxt;
    out_width_r  <= out_width_nxt;
    out_height_r <= out_height_nxt;
    out_fmt_r    <= out_fmt_nxt;
    out_poff_r   <= out_poff_nxt;
    out_pp_r     <= out_pp_nxt;
    out_total_r  <= out_total_nxt;
    out_last_r   <= out_last_nxt;
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall            = (state_r != ST_IDLE);
  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_level_index     = out_index_r;
  assign out_level_offset    = out_offset_r;
  assign out_level_width     = out_width_r;
  assign out_level_height    = out_height_r;
  assign out_texel_format    = out_fmt_r;
  assign out_palette_offset  = out_poff_r;
  assign out_palette_present = out_pp_r;
  assign out_level_total     = out_total_r;
  assign out_last            = out_last_r;

  a_idle_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    !in_stall |-> !out_valid)
    else $error("result pending while accepting requests");

  a_last_frees_input: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && out_last) |=> !in_stall)
    else $error("input not released after final result");

  a_error_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != thml_pkg::STAT_OK) |-> out_last)
    else $error("error result without last");

  a_index_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == thml_pkg::STAT_OK) |->
      ({1'b0, out_level_index} < out_level_total))
    else $error("level index beyond level count");

endmodule

// ===== sim/testbench.sv =====
// Self-checking bench for texture_header_mip_layout: directed header table, then random
// headers; error probes expect a set status, the rest a local mip layout predictor.
// Depends on thml_pkg and the texture_header_mip_layout RTL.
`timescale 1ns / 1ps

module testbench;
  import thml_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 456;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned DRAIN_CYCLES = 150;
  localparam int unsigned CYCLE_LIMIT  = 1_000_000;

  typedef struct packed {
    logic [31:0] blob_size;
    logic [31:0] magic_word;
    logic [7:0]  format_id;
    logic [15:0] picture_count;
    logic [31:0] clut_bytes;
    logic [31:0] image_bytes;
    logic [15:0] pic_header_bytes;
    logic [7:0]  mip_field;
    logic [7:0]  pixel_type;
    logic [15:0] base_width;
    logic [15:0] base_height;
  } hdr_t;

  typedef struct packed {
    logic [3:0]  status;
    logic [3:0]  level_index;
    logic [31:0] level_offset;
    logic [15:0] level_width;
    logic [15:0] level_height;
    logic [1:0]  texel_format;
    logic [31:0] palette_offset;
    logic        palette_present;
    logic [4:0]  level_total;
    logic        last;
  } layout_t;

  typedef struct {
    hdr_t       hdr;
    bit         typed;
    logic [3:0] code;
  } probe_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [31:0] in_blob_size = '0;
  logic [31:0] in_magic_word = '0;
  logic [7:0]  in_format_id = '0;
  logic [15:0] in_picture_count = '0;
  logic [31:0] in_clut_bytes = '0;
  logic [31:0] in_image_bytes = '0;
  logic [15:0] in_pic_header_bytes = '0;
  logic [7:0]  in_mip_field = '0;
  logic [7:0]  in_pixel_type = '0;
  logic [15:0] in_base_width = '0;
  logic [15:0] in_base_height = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [3:0]  out_status;
  logic [3:0]  out_level_index;
  logic [31:0] out_level_offset;
  logic [15:0] out_level_width;
  logic [15:0] out_level_height;
  logic [1:0]  out_texel_format;
  logic [31:0] out_palette_offset;
  logic        out_palette_present;
  logic [4:0]  out_level_total;
  logic        out_last;

  layout_t     pending_layouts[$];
  probe_t      probes[$];
  int unsigned mismatch_cnt = 0;
  int unsigned cycle_cnt = 0;
  bit          quiet_phase = 1'b0;
  bit          hold_request = 1'b0;

  texture_header_mip_layout dut (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) cycle_cnt <= cycle_cnt + 1;

  initial begin : watchdog
    wait (cycle_cnt >= CYCLE_LIMIT);
    $display("texture_header_mip_layout verification failed");
    $finish;
  end

  task automatic flag_error(string msg);
    $display("%0t mismatch: %s", $time, msg);
    mismatch_cnt++;
  endtask

  task automatic compare_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) flag_error($sformatf("%s got %0h, expected %0h", name, got, want));
  endtask

  function automatic void push_fault(logic [3:0] code);
    layout_t r;
    r = '0;
    r.status = code;
    r.last = 1'b1;
    pending_layouts.push_back(r);
  endfunction

  function automatic void predict_layout(hdr_t h);
    layout_t         lv [MAX_MIP_LEVELS];
    longint unsigned pbase, imgoff, span, poff, wd, ht, sz;
    int unsigned     bpp, nlev;
    logic [1:0]      fmt;
    logic            pp;
    if (h.blob_size < FILE_HDR_BYTES) begin
      push_fault(STAT_SHORT);
      return;
    end
    if (h.magic_word != MAGIC_TIM2) begin
      push_fault(STAT_MAGIC);
      return;
    end
    if (h.picture_count == 0) begin
      push_fault(STAT_NOPIC);
      return;
    end
    pbase = 64'((h.format_id == 0) ? FILE_HDR_BYTES : PIC_BASE_WIDE);
    if (h.blob_size < pbase + PIC_HDR_BYTES) begin
      push_fault(STAT_TRUNC);
      return;
    end
    case (h.pixel_type)
      PTYPE_RGBA32: begin
        fmt = FMT_RGBA32;
        bpp = 4;
      end
      PTYPE_RGBA16: begin
        fmt = FMT_RGBA16;
        bpp = 2;
      end
      PTYPE_IDX8: begin
        fmt = FMT_IDX8;
        bpp = 1;
      end
      default: begin
        push_fault(STAT_TYPE);
        return;
      end
    endcase
    nlev = (h.mip_field == 0) ? 1 : h.mip_field;
    if (nlev > MAX_MIP_LEVELS) begin
      push_fault(STAT_MIPS);
      return;
    end
    if (fmt == FMT_IDX8 && h.clut_bytes < PALETTE_BYTES) begin
      push_fault(STAT_NOCLUT);
      return;
    end
    imgoff = pbase + h.pic_header_bytes;
    if (h.pic_header_bytes < PIC_HDR_BYTES || imgoff + h.image_bytes > h.blob_size) begin
      push_fault(STAT_PAYLOAD);
      return;
    end
    span = 0;
    for (int i = 0; i < nlev; i++) begin
      wd = 64'(h.base_width) >> i;
      ht = 64'(h.base_height) >> i;
      if (wd == 0) wd = 1;
      if (ht == 0) ht = 1;
      sz = wd * ht * bpp;
      if (span + sz > h.image_bytes) begin
        push_fault(STAT_LEVEL);
        return;
      end
      lv[i] = '0;
      lv[i].level_index = 4'(i);
      lv[i].level_offset = 32'(imgoff + span);
      lv[i].level_width = 16'(wd);
      lv[i].level_height = 16'(ht);
      span += ((sz + ALIGN_MASK) >> 4) << 4;
    end
    poff = 0;
    pp = 1'b0;
    if (fmt == FMT_IDX8) begin
      poff = imgoff + h.image_bytes;
      if (poff + PALETTE_BYTES > h.blob_size) begin
        push_fault(STAT_CLUTBND);
        return;
      end
      pp = 1'b1;
    end
    for (int i = 0; i < nlev; i++) begin
      lv[i].status = STAT_OK;
      lv[i].texel_format = fmt;
      lv[i].palette_offset = 32'(poff);
      lv[i].palette_present = pp;
      lv[i].level_total = 5'(nlev);
      lv[i].last = (i == nlev - 1);
      pending_layouts.push_back(lv[i]);
    end
  endfunction

  function automatic logic [31:0] fit_image(logic [7:0] pt, logic [7:0] mips,
                                            logic [15:0] bw, logic [15:0] bh);
    longint unsigned need, wd, ht;
    int unsigned     bpp, nlev;
    bpp = (pt == PTYPE_RGBA32) ? 4 : (pt == PTYPE_RGBA16) ? 2 : 1;
    nlev = (mips == 0) ? 1 : mips;
    if (nlev > MAX_MIP_LEVELS) nlev = MAX_MIP_LEVELS;
    need = 0;
    for (int i = 0; i < nlev; i++) begin
      wd = 64'(bw) >> i;
      ht = 64'(bh) >> i;
      if (wd == 0) wd = 1;
      if (ht == 0) ht = 1;
      need += (((wd * ht * bpp) + 15) >> 4) << 4;
    end
    return (need > 32'hFFFF_FFFF) ? 32'hFFFF_FFFF : need[31:0];
  endfunction

  function automatic logic [31:0] blob_for(hdr_t h, longint unsigned slack);
    longint unsigned total;
    total = 64'((h.format_id == 0) ? FILE_HDR_BYTES : PIC_BASE_WIDE);
    total += h.pic_header_bytes + h.image_bytes + slack;
    if (h.pixel_type == PTYPE_IDX8) total += PALETTE_BYTES;
    return (total > 32'hFFFF_FFFF) ? 32'hFFFF_FFFF : total[31:0];
  endfunction

  function automatic hdr_t clean_header(logic [7:0] pt, logic [7:0] mips,
                                        logic [15:0] bw, logic [15:0] bh);
    hdr_t h;
    h.magic_word = MAGIC_TIM2;
    h.format_id = '0;
    h.picture_count = 16'd1;
    h.clut_bytes = 32'(PALETTE_BYTES);
    h.pic_header_bytes = 16'(PIC_HDR_BYTES);
    h.mip_field = mips;
    h.pixel_type = pt;
    h.base_width = bw;
    h.base_height = bh;
    h.image_bytes = fit_image(pt, mips, bw, bh);
    h.blob_size = blob_for(h, 0);
    return h;
  endfunction

  function automatic void add_probe(hdr_t h, bit typed, logic [3:0] code);
    probe_t p;
    p.hdr = h;
    p.typed = typed;
    p.code = code;
    probes.push_back(p);
  endfunction

  function automatic logic [7:0] pick_ptype();
    case ($urandom_range(0, 2))
      0: return PTYPE_RGBA16;
      1: return PTYPE_RGBA32;
      default: return PTYPE_IDX8;
    endcase
  endfunction

  function automatic logic [15:0] pick_dim();
    return ($urandom_range(0, 15) == 0) ? 16'($urandom) : 16'($urandom_range(0, 48));
  endfunction

  function automatic hdr_t random_header();
    hdr_t        h;
    int unsigned r;
    logic [31:0] b;
    r = $urandom_range(0, 99);
    if (r < 15) begin
      h.blob_size = $urandom;
      h.magic_word = $urandom_range(0, 1) ? MAGIC_TIM2 : $urandom;
      h.format_id = 8'($urandom);
      h.picture_count = 16'($urandom);
      h.clut_bytes = $urandom;
      h.image_bytes = $urandom;
      h.pic_header_bytes = 16'($urandom);
      h.mip_field = $urandom_range(0, 1) ? 8'($urandom_range(0, 9)) : 8'($urandom);
      h.pixel_type = $urandom_range(0, 3) == 0 ? 8'($urandom) : pick_ptype();
      h.base_width = 16'($urandom);
      h.base_height = 16'($urandom);
      return h;
    end
    h = clean_header(pick_ptype(), 8'($urandom_range(0, 8)), pick_dim(), pick_dim());
    h.format_id = $urandom_range(0, 1) ? 8'd0 : 8'($urandom);
    h.picture_count = 16'($urandom_range(1, 65535));
    h.pic_header_bytes = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(48, 65535))
                                                     : 16'($urandom_range(48, 96));
    h.clut_bytes = (h.pixel_type == PTYPE_IDX8) ? $urandom_range(1024, 32'hFFFF_FFFF)
                                                : $urandom;
    if (r < 80) begin
      if (h.image_bytes < 32'hF000_0000) h.image_bytes += $urandom_range(0, 40);
      h.blob_size = blob_for(h, $urandom_range(0, 1) ? 0 : $urandom_range(0, 5000));
      return h;
    end
    case ($urandom_range(0, 7))
      0, 1: begin
        h.image_bytes = (h.image_bytes > 24) ? h.image_bytes - $urandom_range(1, 24) : '0;
        h.blob_size = blob_for(h, $urandom_range(0, 64));
      end
      2, 3: begin
        b = blob_for(h, 0);
        h.blob_size = (b > 1100) ? b - $urandom_range(1, 1100) : $urandom_range(0, b);
      end
      4: h.magic_word ^= 32'd1 << $urandom_range(0, 31);
      5: h.mip_field = 8'($urandom_range(9, 255));
      6: h.clut_bytes = $urandom_range(0, 1023);
      default: begin
        h.pic_header_bytes = 16'($urandom_range(0, 47));
        h.blob_size = $urandom_range(0, 200);
      end
    endcase
    return h;
  endfunction

  function automatic int unsigned idle_gap();
    int unsigned r;
    if (quiet_phase) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_request(hdr_t h, bit typed, logic [3:0] code, int unsigned gap);
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_blob_size <= h.blob_size;
    in_magic_word <= h.magic_word;
    in_format_id <= h.format_id;
    in_picture_count <= h.picture_count;
    in_clut_bytes <= h.clut_bytes;
    in_image_bytes <= h.image_bytes;
    in_pic_header_bytes <= h.pic_header_bytes;
    in_mip_field <= h.mip_field;
    in_pixel_type <= h.pixel_type;
    in_base_width <= h.base_width;
    in_base_height <= h.base_height;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (typed) push_fault(code);
    else predict_layout(h);
  endtask

  initial begin : receiver_side
    int unsigned run;
    int unsigned r;
    run = 0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        run = 0;
      end else if (run > 0) begin
        run--;
      end else if (quiet_phase) begin
        out_stall <= 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 50) begin
          out_stall <= 1'b0;
          run = $urandom_range(0, 5);
        end else if (r < 92) begin
          out_stall <= 1'b1;
          run = $urandom_range(0, 2);
        end else begin
          out_stall <= 1'b1;
          run = $urandom_range(7, 39);
        end
      end
    end
  end

  always @(posedge clk) begin : result_check
    layout_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_layouts.size() == 0) begin
        flag_error($sformatf("result with no request pending, status %0d", out_status));
      end else begin
        want = pending_layouts.pop_front();
        compare_field("status", out_status, want.status);
        compare_field("level_index", out_level_index, want.level_index);
        compare_field("level_offset", out_level_offset, want.level_offset);
        compare_field("level_width", out_level_width, want.level_width);
        compare_field("level_height", out_level_height, want.level_height);
        compare_field("texel_format", out_texel_format, want.texel_format);
        compare_field("palette_offset", out_palette_offset, want.palette_offset);
        compare_field("palette_present", out_palette_present, want.palette_present);
        compare_field("level_total", out_level_total, want.level_total);
        compare_field("last", out_last, want.last);
      end
    end
  end

  initial begin : stimulus
    hdr_t h;
    h = clean_header(PTYPE_RGBA32, 0, 4, 4);
    h.blob_size = '0;
    add_probe(h, 1'b1, STAT_SHORT);
    h.blob_size = 32'd15;
    h.magic_word = '0;
    add_probe(h, 1'b1, STAT_SHORT);
    h.blob_size = 32'd16;
    h.magic_word = ~MAGIC_TIM2;
    add_probe(h, 1'b1, STAT_MAGIC);
    h.blob_size = 32'hFFFF_FFFF;
    h.magic_word = MAGIC_TIM2 ^ 32'h8000_0000;
    add_probe(h, 1'b1, STAT_MAGIC);
    h = clean_header(PTYPE_RGBA32, 0, 4, 4);
    h.picture_count = '0;
    add_probe(h, 1'b1, STAT_NOPIC);
    h = clean_header(PTYPE_RGBA32, 0, 4, 4);
    h.blob_size = 32'd63;
    add_probe(h, 1'b1, STAT_TRUNC);
    h.format_id = 8'hFF;
    h.blob_size = 32'd175;
    add_probe(h, 1'b1, STAT_TRUNC);
    h = clean_header(8'h00, 0, 4, 4);
    add_probe(h, 1'b1, STAT_TYPE);
    h.pixel_type = 8'hFF;
    add_probe(h, 1'b1, STAT_TYPE);
    h.pixel_type = 8'h02;
    add_probe(h, 1'b1, STAT_TYPE);
    h = clean_header(PTYPE_RGBA16, 8, 16, 16);
    h.mip_field = 8'd9;
    add_probe(h, 1'b1, STAT_MIPS);
    h.mip_field = 8'hFF;
    add_probe(h, 1'b1, STAT_MIPS);
    h = clean_header(PTYPE_IDX8, 0, 2, 2);
    h.clut_bytes = PALETTE_BYTES - 1;
    add_probe(h, 1'b1, STAT_NOCLUT);
    h = clean_header(PTYPE_RGBA16, 0, 2, 2);
    h.pic_header_bytes = PIC_HDR_BYTES - 1;
    add_probe(h, 1'b1, STAT_PAYLOAD);
    h.pic_header_bytes = PIC_HDR_BYTES;
    h.image_bytes = 32'hFFFF_FFFF;
    h.blob_size = 32'hFFFF_FFFF;
    add_probe(h, 1'b1, STAT_PAYLOAD);
    h = clean_header(PTYPE_RGBA32, 0, 1, 1);
    h.image_bytes = '0;
    h.blob_size = blob_for(h, 0);
    add_probe(h, 1'b1, STAT_LEVEL);
    h = clean_header(PTYPE_RGBA32, 1, 16'hFFFF, 16'hFFFF);
    h.image_bytes = 32'hFFFF_0000;
    h.blob_size = 32'hFFFF_FFFF;
    add_probe(h, 1'b1, STAT_LEVEL);
    h = clean_header(PTYPE_IDX8, 3, 16, 16);
    h.blob_size = h.blob_size - 1;
    add_probe(h, 1'b1, STAT_CLUTBND);
    add_probe(clean_header(PTYPE_RGBA32, 0, 0, 0), 1'b0, STAT_OK);
    add_probe(clean_header(PTYPE_RGBA16, 8, 16'hFFFF, 1), 1'b0, STAT_OK);
    h = clean_header(PTYPE_IDX8, 8, 1, 16'hFFFF);
    h.format_id = 8'hFF;
    h.picture_count = 16'hFFFF;
    h.clut_bytes = 32'hFFFF_FFFF;
    h.blob_size = blob_for(h, 0);
    add_probe(h, 1'b0, STAT_OK);
    h = clean_header(PTYPE_RGBA32, 8, 37, 5);
    h.pic_header_bytes = 16'hFFFF;
    h.blob_size = blob_for(h, 0);
    add_probe(h, 1'b0, STAT_OK);
    add_probe(clean_header(PTYPE_IDX8, 1, 3, 3), 1'b0, STAT_OK);
    add_probe(clean_header(PTYPE_RGBA16, 2, 7, 9), 1'b0, STAT_OK);

    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    foreach (probes[i]) send_request(probes[i].hdr, probes[i].typed, probes[i].code, idle_gap());
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      quiet_phase = (n >= 150 && n < 230);
      if (n == 300) hold_request = 1'b1;
      send_request(random_header(), 1'b0, STAT_OK, idle_gap());
    end
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_layouts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("texture_header_mip_layout verification clean");
    end else begin
      $display("texture_header_mip_layout verification failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/thml_pkg.sv
sv/thml_addcmp.sv
sv/thml_level_unit.sv
sv/texture_header_mip_layout.sv
sim/testbench.sv
